// ===== design/rgb_pixel_plane_extractor_unit_defines.svh =====
// Assertion macros shared by the RGB pixel plane extractor RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef RGB_PIXEL_PLANE_EXTRACTOR_UNIT_DEFINES_SVH
`define RGB_PIXEL_PLANE_EXTRACTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBPX_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbpx same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBPX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbpx next-cycle check failed");

`endif

// ===== design/rgbpx_pkg.sv =====
// Package for the RGB pixel plane extractor: widths, Q16 weights, register
// indexes, pipeline control type and the square root step function.
// Depends on nothing.
package rgbpx_pkg;

    localparam int PIX_W       = 8;
    localparam int POS_W       = 11;
    localparam int WIDTH_W     = 12;
    localparam int MARGIN_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int MAX_WIDTH   = 2048;
    localparam int NUM_STAGES  = 7;
    localparam int SQRT_STAGES = 4;
    localparam int SQRT_REM_W  = 17;
    localparam int SUMSQ_W     = 18;
    localparam int WPROD_W     = 24;
    localparam int CPROD_W     = 27;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(640);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET    = MARGIN_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = CFG_IDX_W'(1);

    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;
    localparam logic signed [17:0] SCALE_U = 18'sd46727;
    localparam logic signed [17:0] SCALE_V = 18'sd36962;

    // floor(x / 3) equals (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2^19.
    localparam logic [17:0] DIV3_RECIP = 18'd174763;
    localparam int DIV3_SHIFT = 19;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [SQRT_REM_W-1:0] rem;
        logic [PIX_W-1:0]      root;
    } sqrt_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] yellow;
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
        logic             inner;
    } side_t;

    // One digit of the restoring square root: try setting root bit bit_pos.
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input int bit_pos);
        logic [SQRT_REM_W-1:0] trial;
        sqrt_state_t r;
        trial = (SQRT_REM_W'(s.root) << (bit_pos + 1)) + (SQRT_REM_W'(1) << (2 * bit_pos));
        r = s;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = s.root | (PIX_W'(1) << bit_pos);
        end
        return r;
    endfunction

    // floor(p / 65536) + 128, clamped to 0..255.
    function automatic logic [PIX_W-1:0] sat_chroma(input logic signed [CPROD_W-1:0] p);
        logic signed [CPROD_W-17:0] f;
        logic signed [CPROD_W-15:0] v;
        logic [PIX_W-1:0] r;
        f = p[CPROD_W-1:16];
        v = (CPROD_W-14)'(f) + (CPROD_W-14)'(128);
        if (v < 0)
            r = '0;
        else if (v > (CPROD_W-14)'(255))
            r = '1;
        else
            r = v[PIX_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/rgbpx_datapath.sv =====
// Payload pipeline of the RGB pixel plane extractor: products, sums,
// division by three, chroma scaling and a four-stage square root.
// Depends on rgbpx_pkg; stage loads come from the top-level control.
module rgbpx_datapath (
    input  logic                                clk,
    input  rgbpx_pkg::pipe_ctrl_t               ctrl,
    input  logic [rgbpx_pkg::PIX_W-1:0]         red,
    input  logic [rgbpx_pkg::PIX_W-1:0]         green,
    input  logic [rgbpx_pkg::PIX_W-1:0]         blue,
    input  logic [rgbpx_pkg::POS_W-1:0]         row,
    input  logic [rgbpx_pkg::POS_W-1:0]         col,
    input  logic [rgbpx_pkg::WIDTH_W-1:0]       line_width,
    input  logic [rgbpx_pkg::MARGIN_W-1:0]      margin,
    output logic [rgbpx_pkg::PIX_W-1:0]         yellow,
    output logic [rgbpx_pkg::PIX_W-1:0]         intensity,
    output logic [rgbpx_pkg::PIX_W-1:0]         luma,
    output logic [rgbpx_pkg::PIX_W-1:0]         chroma_u,
    output logic [rgbpx_pkg::PIX_W-1:0]         chroma_v,
    output logic                                inner
);
    import rgbpx_pkg::*;

    logic [15:0]          sq_r_reg, sq_g_reg, sq_b_reg;
    logic [WPROD_W-1:0]   wr_reg, wg_reg, wb_reg;
    logic [PIX_W-1:0]     r1_reg, b1_reg, yel1_reg;
    logic                 inner1_reg;
    logic                 inner_next;

    logic [SUMSQ_W-1:0]   sumsq2_reg;
    logic [PIX_W-1:0]     luma2_reg, r2_reg, b2_reg, yel2_reg;
    logic                 inner2_reg;
    logic [WPROD_W:0]     wsum;

    logic [15:0]                 q3_reg;
    logic signed [CPROD_W-1:0]   pu3_reg, pv3_reg;
    logic [PIX_W-1:0]            luma3_reg, yel3_reg;
    logic                        inner3_reg;
    logic [2*SUMSQ_W-1:0]        div_prod;
    logic signed [PIX_W:0]       diff_u, diff_v;

    sqrt_state_t sq_reg [SQRT_STAGES];
    sqrt_state_t sq_next [SQRT_STAGES];
    side_t       side_reg [SQRT_STAGES];
    side_t       side_first;

    always_comb
    begin
        inner_next = (row >= POS_W'(margin))
                  && (col >= POS_W'(margin))
                  && ((WIDTH_W'(col) + WIDTH_W'(margin)) < line_width);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            sq_r_reg   <= 16'(red) * 16'(red);
            sq_g_reg   <= 16'(green) * 16'(green);
            sq_b_reg   <= 16'(blue) * 16'(blue);
            wr_reg     <= WPROD_W'(WEIGHT_R) * WPROD_W'(red);
            wg_reg     <= WPROD_W'(WEIGHT_G) * WPROD_W'(green);
            wb_reg     <= WPROD_W'(WEIGHT_B) * WPROD_W'(blue);
            r1_reg     <= red;
            b1_reg     <= blue;
            yel1_reg   <= (red >> 1) + (green >> 1);
            inner1_reg <= inner_next;
        end
    end

    assign wsum = (WPROD_W+1)'(wr_reg) + (WPROD_W+1)'(wg_reg) + (WPROD_W+1)'(wb_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            sumsq2_reg <= SUMSQ_W'(sq_r_reg) + SUMSQ_W'(sq_g_reg) + SUMSQ_W'(sq_b_reg);
            luma2_reg  <= wsum[23:16];
            r2_reg     <= r1_reg;
            b2_reg     <= b1_reg;
            yel2_reg   <= yel1_reg;
            inner2_reg <= inner1_reg;
        end
    end

    assign div_prod = (2*SUMSQ_W)'(sumsq2_reg) * (2*SUMSQ_W)'(DIV3_RECIP);
    assign diff_u   = $signed({1'b0, r2_reg}) - $signed({1'b0, luma2_reg});
    assign diff_v   = $signed({1'b0, b2_reg}) - $signed({1'b0, luma2_reg});

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            q3_reg     <= div_prod[DIV3_SHIFT+15:DIV3_SHIFT];
            pu3_reg    <= CPROD_W'(diff_u) * CPROD_W'(SCALE_U);
            pv3_reg    <= CPROD_W'(diff_v) * CPROD_W'(SCALE_V);
            luma3_reg  <= luma2_reg;
            yel3_reg   <= yel2_reg;
            inner3_reg <= inner2_reg;
        end
    end

    always_comb
    begin
        side_first.yellow   = yel3_reg;
        side_first.luma     = luma3_reg;
        side_first.chroma_u = sat_chroma(pu3_reg);
        side_first.chroma_v = sat_chroma(pv3_reg);
        side_first.inner    = inner3_reg;
    end

    // Each square root stage resolves two bits of the root, most significant first.
    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        sqrt_state_t stage_in;
        side_t       side_in;

        if (j == 0)
        begin : g_head
            always_comb
            begin
                stage_in.rem  = SQRT_REM_W'(q3_reg);
                stage_in.root = '0;
                side_in       = side_first;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                stage_in = sq_reg[j-1];
                side_in  = side_reg[j-1];
            end
        end

        always_comb
        begin
            sq_next[j] = sqrt_step(sqrt_step(stage_in, PIX_W - 1 - 2 * j), PIX_W - 2 - 2 * j);
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.load[3+j])
            begin
                sq_reg[j]   <= sq_next[j];
                side_reg[j] <= side_in;
            end
        end
    end

    assign yellow    = side_reg[SQRT_STAGES-1].yellow;
    assign intensity = sq_reg[SQRT_STAGES-1].root;
    assign luma      = side_reg[SQRT_STAGES-1].luma;
    assign chroma_u  = side_reg[SQRT_STAGES-1].chroma_u;
    assign chroma_v  = side_reg[SQRT_STAGES-1].chroma_v;
    assign inner     = side_reg[SQRT_STAGES-1].inner;

endmodule

// ===== design/rgb_pixel_plane_extractor_unit.sv =====
// Top level of the RGB pixel plane extractor: handshake control, valid
// pipeline and configuration registers. Depends on rgbpx_pkg, rgbpx_datapath
// and rgb_pixel_plane_extractor_unit_defines.svh.
//
// The input channel (in_valid, in_ready) carries one RGB pixel word with its
// row and column. The output channel (out_valid, out_ready) returns one word
// per pixel: yellow, intensity, luma, chroma_u, chroma_v and the inner flag.
// Words leave in the order they arrived.
// The configuration channel (cfg_valid, cfg_ready) writes line_width at index
// 0 and margin at index 1; other indexes are ignored. cfg_ready is always high.
// Write configuration only while no pixel is in flight.
// The seven register stages between input acceptance and out_valid are two
// for products and sums, one for the divide by three and chroma scaling, and
// four for the square root at two bits per stage.
// Throughput is one pixel per cycle while the receiver does not stall.
// When the receiver stalls, each stage holds its word and empty stages still
// fill, so in_ready stays high until all seven stages hold a word.
// Reset empties the pipeline and sets line_width to 640 and margin to 5.
`include "rgb_pixel_plane_extractor_unit_defines.svh"

module rgb_pixel_plane_extractor_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rgbpx_pkg::PIX_W-1:0]         red,
    input  logic [rgbpx_pkg::PIX_W-1:0]         green,
    input  logic [rgbpx_pkg::PIX_W-1:0]         blue,
    input  logic [rgbpx_pkg::POS_W-1:0]         row,
    input  logic [rgbpx_pkg::POS_W-1:0]         col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbpx_pkg::PIX_W-1:0]         yellow,
    output logic [rgbpx_pkg::PIX_W-1:0]         intensity,
    output logic [rgbpx_pkg::PIX_W-1:0]         luma,
    output logic [rgbpx_pkg::PIX_W-1:0]         chroma_u,
    output logic [rgbpx_pkg::PIX_W-1:0]         chroma_v,
    output logic                                inner,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbpx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbpx_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rgbpx_pkg::*;

    logic [NUM_STAGES-1:0]  vld_reg, vld_next;
    logic [NUM_STAGES:0]    rdy;
    pipe_ctrl_t             ctrl;
    logic [WIDTH_W-1:0]     line_width_reg, line_width_next;
    logic [MARGIN_W-1:0]    margin_reg, margin_next;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        ctrl.load = rdy[NUM_STAGES-1:0];
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!rdy[k])
                vld_next[k] = vld_reg[k];
            else if (k == 0)
                vld_next[k] = in_valid;
            else
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_comb
    begin
        line_width_next = line_width_reg;
        margin_next     = margin_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH:
                begin
                    if (cfg_data > CFG_DATA_W'(MAX_WIDTH))
                        line_width_next = WIDTH_W'(MAX_WIDTH);
                    else
                        line_width_next = cfg_data;
                end
                REG_MARGIN:
                begin
                    margin_next = cfg_data[MARGIN_W-1:0];
                end
                default:
                begin
                    line_width_next = line_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            margin_reg     <= MARGIN_RESET;
        end
        else
        begin
            line_width_reg <= line_width_next;
            margin_reg     <= margin_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    rgbpx_datapath u_datapath (
        .clk        (clk),
        .ctrl       (ctrl),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .row        (row),
        .col        (col),
        .line_width (line_width_reg),
        .margin     (margin_reg),
        .yellow     (yellow),
        .intensity  (intensity),
        .luma       (luma),
        .chroma_u   (chroma_u),
        .chroma_v   (chroma_v),
        .inner      (inner)
    );

    `RGBPX_ASSERT_SAME(a_width_bounded, 1'b1, line_width_reg <= WIDTH_W'(MAX_WIDTH))
    `RGBPX_ASSERT_SAME(a_ready_when_hole, vld_reg != '1, in_ready)
    `RGBPX_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0])
    `RGBPX_ASSERT_NEXT(a_stage0_holds, vld_reg[0] && !rdy[1], vld_reg[0])

endmodule
